@@ rtl/scanline_polygon_crossings_assert.svh @@
// Assertion macros for the scanline polygon crossings block.
`ifndef SCANLINE_POLYGON_CROSSINGS_ASSERT_SVH
`define SCANLINE_POLYGON_CROSSINGS_ASSERT_SVH
// An implication checked on every clock edge outside reset.
`define SPC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// A next-cycle implication checked outside reset.
`define SPC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/spc_pkg.sv @@
// Package of types and constants for the scanline polygon crossings block.
package spc_pkg;
    localparam int MAX_VERTICES_DEF = 8;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int RESULT_LIMIT     = 8;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [2:0]  vertex_index;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_z;
        logic signed [31:0] scan_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] crossing_x;
        logic        crossing_valid;
        logic [3:0]  crossing_total;
        logic        is_last;
    } t_out_item;
endpackage

@@ rtl/spc_if.sv @@
// Valid/ready channel interfaces for the block.
interface spc_in_if;
    import spc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spc_out_if;
    import spc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spc_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/spc_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
module spc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/scanline_polygon_crossings.sv @@
// Top level of the scanline polygon crossings block.
//
//  channel   dir  beat contents
//  i_in      in   operation, vertex_index, vertex_x, vertex_z, scan_z
//  o_out     out  crossing_x, crossing_valid, crossing_total, is_last
//  i_cfg     in   vertex_count
//
// A query takes each edge through S_FIX (start), S_RD1 (read of the first vertex),
// S_RD2 (read of the second) and S_TEST (edge test). A crossed edge adds a restoring
// division in S_DIV, saturation in S_FIX and an S_SORTR/S_SORTC pair for each buffer
// entry that the insertion sort shifts plus one pair to place it. Each result beat
// passes S_OUTR and S_OUT. Reset is synchronous, active low, and resets only r_state,
// r_ovalid and r_count. A stalled output holds its beat; i_in takes no item mid query.
module scanline_polygon_crossings
    import spc_pkg::*;
#(
    parameter int MAX_VERTICES = spc_pkg::MAX_VERTICES_DEF,
    parameter int FRAC_BITS    = spc_pkg::FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    spc_in_if.sink    i_in,
    spc_out_if.source o_out,
    spc_cfg_if.sink   i_cfg
);
    `include "scanline_polygon_crossings_assert.svh"

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int LIM = (MAX_VERTICES < RESULT_LIMIT) ? MAX_VERTICES : RESULT_LIMIT;
    // FRAC_BITS cancels out of the interpolation.

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD1   = 10'b0000000010,
        S_RD2   = 10'b0000000100,
        S_TEST  = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_FIX   = 10'b0000100000,
        S_SORTR = 10'b0001000000,
        S_SORTC = 10'b0010000000,
        S_OUTR  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [3:0] r_count;
    logic [3:0] r_n, r_edge, r_cnt, r_k, r_oi;
    logic signed [31:0] r_z;
    logic signed [32:0] r_x1, r_z1;
    logic [63:0] r_prod;
    logic [32:0] r_den, r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_bit;
    logic        r_neg;
    logic signed [31:0] r_xnew;
    logic        r_ovalid;
    t_out_item   r_odata;

    // Vertex RAM ports.
    logic           vx_we;
    logic [AW-1:0]  v_raddr;
    logic [31:0]    vx_rd, vz_rd;
    // Crossing buffer RAM ports.
    logic           cb_we;
    logic [2:0]     cb_waddr, cb_raddr;
    logic [31:0]    cb_wdata, cb_rd;

    wire in_fire  = i_in.valid && i_in.ready;
    wire out_fire = o_out.valid && o_out.ready;

    assign vx_we = in_fire && i_in.data.operation == OP_WRITE &&
                   32'(i_in.data.vertex_index) < 32'(MAX_VERTICES);

    spc_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vx (
        .i_clk, .i_we(vx_we), .i_waddr(AW'(i_in.data.vertex_index)),
        .i_wdata(i_in.data.vertex_x), .i_raddr(v_raddr), .o_rdata(vx_rd));
    spc_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vz (
        .i_clk, .i_we(vx_we), .i_waddr(AW'(i_in.data.vertex_index)),
        .i_wdata(i_in.data.vertex_z), .i_raddr(v_raddr), .o_rdata(vz_rd));
    spc_ram #(.WIDTH(32), .DEPTH(RESULT_LIMIT)) u_cb (
        .i_clk, .i_we(cb_we), .i_waddr(cb_waddr), .i_wdata(cb_wdata),
        .i_raddr(cb_raddr), .o_rdata(cb_rd));

    // Next edge index with wrap.
    logic [3:0] next_edge;
    assign next_edge = (r_edge + 4'd1 < r_n) ? r_edge + 4'd1 : 4'd0;

    // Vertex read address: the first endpoint from S_FIX, the second held through
    // S_RD1 and S_RD2 so that it is still on the read port during S_TEST.
    always_comb begin
        if (r_state == S_RD1 || r_state == S_RD2) begin
            v_raddr = AW'(next_edge);
        end else begin
            v_raddr = AW'(r_edge);
        end
    end

    // Edge test on the second endpoint read, first is held in r_x1/r_z1.
    logic signed [32:0] x2, z2, dx, dzq, dz, zs;
    logic hit;
    logic [32:0] adx, adzq, adz;
    always_comb begin
        x2  = 33'(signed'(vx_rd));
        z2  = 33'(signed'(vz_rd));
        zs  = 33'(r_z);
        dx  = x2 - r_x1;
        dzq = zs - r_z1;
        dz  = z2 - r_z1;
        hit = (r_z1 != z2) && ((zs >= r_z1 && zs <= z2) || (zs <= r_z1 && zs >= z2));
        adx  = dx[32]  ? -dx  : dx;
        adzq = dzq[32] ? -dzq : dzq;
        adz  = dz[32]  ? -dz  : dz;
    end

    // Divider step: one quotient bit per cycle.
    logic [33:0] rem_sh;
    logic        ge;
    assign rem_sh = {r_rem, r_prod[63]};
    assign ge = rem_sh >= {1'b0, r_den};

    // Crossing with sign and saturation (quotient magnitude < 2^33).
    logic signed [34:0] xsum;
    logic signed [31:0] xsat;
    always_comb begin
        xsum = 35'(r_x1) + (r_neg ? -35'(r_quo[33:0]) : 35'(r_quo[33:0]));
        if (xsum > 35'sd2147483647) begin
            xsat = 32'h7fffffff;
        end else if (xsum < -35'sd2147483648) begin
            xsat = 32'h80000000;
        end else begin
            xsat = xsum[31:0];
        end
    end

    // Buffer write and read addresses for insertion sort and output.
    always_comb begin
        cb_we    = 1'b0;
        cb_waddr = r_k[2:0];
        cb_wdata = r_xnew;
        cb_raddr = r_k[2:0] - 3'd1;
        if (r_state == S_SORTC) begin
            if (r_k != 0 && $signed(cb_rd) > r_xnew) begin
                cb_we = 1'b1;
                cb_wdata = cb_rd;
            end else begin
                cb_we = 1'b1;
            end
        end
        if (r_state == S_OUTR || r_state == S_OUT) begin
            cb_raddr = r_oi[2:0];
        end
    end

    assign i_in.ready  = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= 4'd4;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_count <= i_cfg.data;
            end
            if (out_fire && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && i_in.data.operation == OP_QUERY) begin
                        r_z    <= i_in.data.scan_z;
                        r_n    <= (r_count > 4'(LIM)) ? 4'(LIM) : r_count;
                        r_edge <= 4'd0;
                        r_cnt  <= 4'd0;
                        r_state <= S_FIX;
                        r_bit  <= 7'd0;
                    end
                end
                S_FIX: begin
                    // Either starting an edge, finishing a division or, once every edge is done, going to output.
                    if (r_bit != 0) begin
                        r_xnew  <= xsat;
                        r_k     <= r_cnt;
                        r_bit   <= 7'd0;
                        r_state <= S_SORTR;
                    end else if (r_edge >= r_n) begin
                        r_oi    <= 4'd0;
                        r_state <= S_OUTR;
                    end else begin
                        r_state <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_x1 <= 33'(signed'(vx_rd));
                    r_z1 <= 33'(signed'(vz_rd));
                    r_state <= S_RD2;
                end
                S_RD2: r_state <= S_TEST;
                S_TEST: begin
                    if (hit && r_cnt < 4'(RESULT_LIMIT)) begin
                        r_prod <= 64'(adx[31:0]) * 64'(adzq[31:0]);
                        r_den  <= adz;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_bit  <= 7'd64;
                        r_neg  <= (dx[32] != (dzq[32] ? !dz[32] : dz[32]));
                        r_state <= S_DIV;
                    end else begin
                        r_edge  <= r_edge + 4'd1;
                        r_state <= S_FIX;
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];
                    r_quo  <= {r_quo[62:0], ge};
                    r_prod <= {r_prod[62:0], 1'b0};
                    // The count stops at one, which tells S_FIX a quotient is ready.
                    r_bit  <= (r_bit == 7'd1) ? 7'd1 : r_bit - 7'd1;
                    if (r_bit == 7'd1) begin
                        r_state <= S_FIX;
                    end
                end
                S_SORTR: r_state <= S_SORTC;
                S_SORTC: begin
                    if (r_k != 0 && $signed(cb_rd) > r_xnew) begin
                        r_k     <= r_k - 4'd1;
                        r_state <= S_SORTR;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_edge  <= r_edge + 4'd1;
                        r_state <= S_FIX;
                    end
                end
                S_OUTR: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || out_fire) begin
                        r_ovalid <= 1'b1;
                        r_odata.crossing_x     <= (r_cnt == 0) ? 32'sd0 : cb_rd;
                        r_odata.crossing_valid <= r_cnt != 0;
                        r_odata.crossing_total <= r_cnt;
                        r_odata.is_last <= (r_cnt == 0) || (r_oi + 4'd1 == r_cnt);
                        if (r_cnt == 0 || r_oi + 4'd1 == r_cnt) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oi    <= r_oi + 4'd1;
                            r_state <= S_OUTR;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output beat holds while stalled; no input is taken mid query.
    `SPC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, $stable(o_out.data))
    `SPC_ASSERT_IMP(a_busy, i_clk, i_rst_n, r_state != S_IDLE, !i_in.ready)
    `SPC_ASSERT_IMP(a_cnt, i_clk, i_rst_n, 1'b1, r_cnt <= 4'(RESULT_LIMIT) || r_state == S_IDLE)
endmodule
